// ===== sv/esd_pkg.sv =====
// Shared types, character constants and decode helpers for the escape decoder.
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  // Escape parser mode
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2,
    MODE_OCTAL  = 2'd3
  } mode_e;

  // Characters with a role in the grammar
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;  // backslash
  localparam logic [7:0] CH_X     = 8'h78;  // x
  localparam logic [7:0] CH_DQ    = 8'h22;  // double quote
  localparam logic [7:0] CH_QM    = 8'h3F;  // question mark
  localparam logic [7:0] CH_SQ    = 8'h27;  // single quote
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  // Control codes
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_TAB = 8'd9;
  localparam logic [7:0] CODE_BEL = 8'd7;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] CODE_VT  = 8'd11;

  // Result queue geometry
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       eos;
  } result_t;

  // Up to two results caused by one item
  typedef struct packed {
    logic [1:0]       cnt;
    result_t [1:0]    res;
  } result_pair_t;

  typedef struct packed {
    logic       simple;
    logic [7:0] code;
  } esc_code_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic esc_code_t escape_code(logic [7:0] c);
    esc_code_t r;
    r.simple = 1'b1;
    r.code   = c;
    unique case (c)
      CH_N:    r.code = CODE_LF;
      CH_T:    r.code = CODE_TAB;
      CH_A:    r.code = CODE_BEL;
      CH_B:    r.code = CODE_BS;
      CH_F:    r.code = CODE_FF;
      CH_R:    r.code = CODE_CR;
      CH_V:    r.code = CODE_VT;
      CH_BSL, CH_DQ, CH_QM, CH_SQ: r.code = c;
      default: begin
        r.simple = 1'b0;
        r.code   = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic hex_digit_t hex_digit(logic [7:0] c);
    hex_digit_t r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      r = '{valid: 1'b1, nibble: d[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
      r = '{valid: 1'b1, nibble: d[3:0]};
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 8'd10;
      r = '{valid: 1'b1, nibble: d[3:0]};
    end
    return r;
  endfunction

  // Append one byte result
  function automatic result_pair_t put_byte(result_pair_t p, logic [7:0] b);
    result_pair_t q;
    q = p;
    q.res[p.cnt[0]] = '{out_byte: b, has_byte: 1'b1, eos: 1'b0};
    q.cnt = p.cnt + 2'd1;
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== sv/escape_sequence_decoder.sv =====
// Top level of the C string escape decoder: input register, decode and result queue.
//
// Usage: characters enter on the input channel (ch_i, is_last_i) under
// in_valid_i / in_ready_o; decoded bytes leave on the output channel
// (out_byte_o, has_byte_o, end_of_string_o) under out_valid_o / out_ready_i.
// A backslash opens an escape; simple letters, \x hex and octal escapes are
// decoded, and a zero character or is_last_i closes the string. The final
// result of a string carries end_of_string_o; a string end with nothing to
// give yields one result with has_byte_o low.
// Path: an accepted item waits in the input register, is decoded
// combinationally once the queue has room, and is written into the queue, whose head is offered.
// Throughput: one item per cycle while out_ready_i is high and each item yields at most one result;
// an item that yields two results takes the single output port twice,
// which sets the sustained rate to one result per cycle.
// Stall: results wait in a four-entry queue; while fewer than two entries are
// free the decode holds and the input register holds its item, so in_ready_o
// drops once that register is full.
// Reset: clears the parser to normal mode and empties the queue and the
// input register.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder
  import esd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] ch_i,
  input  wire logic       is_last_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic [7:0] out_byte_o,
  output      logic       has_byte_o,
  output      logic       end_of_string_o
);

  logic         in_valid_q;
  logic [7:0]   ch_q;
  logic         last_q;
  logic         room;
  logic         fire;
  result_pair_t pair;
  result_t      head;

  assign fire       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q   <= ch_i;
      last_q <= is_last_i;
    end
  end

  esd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .ch_i      (ch_q),
    .is_last_i (last_q),
    .pair_o    (pair)
  );

  esd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .pair_i  (pair),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (head)
  );

  assign out_byte_o      = head.out_byte;
  assign has_byte_o      = head.has_byte;
  assign end_of_string_o = head.eos;

endmodule

`default_nettype wire

// ===== sv/esd_decode.sv =====
// Escape parser state and combinational decode of one character into up to two results.
`timescale 1ns / 1ps
`default_nettype none

module esd_decode
  import esd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         fire_i,
  input  wire logic [7:0]   ch_i,
  input  wire logic         is_last_i,
  output      result_pair_t pair_o
);

  mode_e      mode_q, mode_d;
  logic [1:0] cnt_q, cnt_d;
  logic [8:0] val_q, val_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      cnt_q  <= '0;
      val_q  <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      val_q  <= val_d;
    end
  end

  always_comb begin
    result_pair_t p;
    esc_code_t    esc;
    hex_digit_t   hx;
    logic         is_oct;
    logic         do_plain;
    logic         do_finish;
    logic [7:0]   oct;

    p        = '0;
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    val_d    = val_q;
    esc      = escape_code(ch_i);
    hx       = hex_digit(ch_i);
    is_oct   = (ch_i >= CH_0) && (ch_i <= CH_7);
    oct      = ch_i - CH_0;
    do_plain = 1'b0;
    do_finish = (ch_i == CH_NUL) || is_last_i;

    if (ch_i != CH_NUL) begin
      unique case (mode_q)
        MODE_NORMAL: do_plain = 1'b1;
        MODE_ESCAPE: begin
          if (esc.simple) begin
            p = put_byte(p, esc.code);
            mode_d = MODE_NORMAL;
            cnt_d  = '0;
            val_d  = '0;
          end else if (ch_i == CH_X) begin
            mode_d = MODE_HEX;
            cnt_d  = '0;
            val_d  = '0;
          end else if (is_oct) begin
            mode_d = MODE_OCTAL;
            cnt_d  = 2'd1;
            val_d  = {6'd0, oct[2:0]};
          end else begin
            // escape with no digits: emit zero, then handle the character
            p = put_byte(p, 8'h00);
            mode_d = MODE_NORMAL;
            cnt_d  = '0;
            val_d  = '0;
            do_plain = 1'b1;
          end
        end
        MODE_HEX: begin
          if (hx.valid) begin
            val_d = {val_q[4:0], hx.nibble};
            if (cnt_q >= 2'd1) begin
              p = put_byte(p, val_d[7:0]);
              mode_d = MODE_NORMAL;
              cnt_d  = '0;
              val_d  = '0;
            end else begin
              cnt_d = 2'd1;
            end
          end else begin
            p = put_byte(p, val_q[7:0]);
            mode_d = MODE_NORMAL;
            cnt_d  = '0;
            val_d  = '0;
            do_plain = 1'b1;
          end
        end
        MODE_OCTAL: begin
          if (is_oct) begin
            val_d = {val_q[5:0], oct[2:0]};
            if (cnt_q >= 2'd2) begin
              p = put_byte(p, val_d[7:0]);
              mode_d = MODE_NORMAL;
              cnt_d  = '0;
              val_d  = '0;
            end else begin
              cnt_d = cnt_q + 2'd1;
            end
          end else begin
            p = put_byte(p, val_q[7:0]);
            mode_d = MODE_NORMAL;
            cnt_d  = '0;
            val_d  = '0;
            do_plain = 1'b1;
          end
        end
        default: ;
      endcase

      if (do_plain) begin
        if (ch_i == CH_BSL) begin
          mode_d = MODE_ESCAPE;
          cnt_d  = '0;
          val_d  = '0;
        end else begin
          p = put_byte(p, ch_i);
        end
      end
    end

    if (do_finish) begin
      // flush a pending numeric escape; a lone backslash is dropped
      if (mode_d == MODE_HEX || mode_d == MODE_OCTAL) begin
        p = put_byte(p, val_d[7:0]);
      end
      mode_d = MODE_NORMAL;
      cnt_d  = '0;
      val_d  = '0;
      if (p.cnt == 2'd0) begin
        p.res[0] = '{out_byte: 8'h00, has_byte: 1'b0, eos: 1'b1};
        p.cnt    = 2'd1;
      end else begin
        p.res[p.cnt[1]].eos = 1'b1;
      end
    end

    pair_o = p;
  end

`ifndef SYNTHESIS
  // a full octal escape never stays pending with three digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_OCTAL) |-> (cnt_q == 2'd1 || cnt_q == 2'd2))
    else $error("octal digit count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_HEX) |-> (cnt_q != 2'd2 && cnt_q != 2'd3))
    else $error("hex digit count out of range");

  // end of string returns the parser to normal mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (ch_i == CH_NUL || is_last_i)) |=> (mode_q == MODE_NORMAL))
    else $error("parser not reset after end of string");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_o.cnt != 2'd3)
    else $error("too many results for one item");
`endif

endmodule

`default_nettype wire

// ===== sv/esd_fifo.sv =====
// Result queue that takes up to two results per cycle and gives one.
`timescale 1ns / 1ps
`default_nettype none

module esd_fifo
  import esd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire result_pair_t pair_i,
  output      logic         room_o,
  output      logic         valid_o,
  input  wire logic         ready_i,
  output      result_t      data_o
);

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [1:0]          push_n;
  logic                pop;

  assign push_n  = push_i ? pair_i.cnt : 2'd0;
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];
  // room for a full pair regardless of this cycle's pop
  assign room_o  = (cnt_q <= FifoCntW'(FifoDepth - 2));
  assign cnt_d   = cnt_q + FifoCntW'(push_n) - FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FifoPtrW'(push_n);
      rd_q  <= rd_q + FifoPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= pair_i.res[0];
    end
    if (push_n == 2'd2) begin
      mem_q[wr_q + FifoPtrW'(1)] <= pair_i.res[1];
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0) |-> room_o)
    else $error("push into queue without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == FifoPtrW'(cnt_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire
